// File: hdl/utf8_to_utf16_stream_decoder_assert.svh
// Assertion macros for the UTF-8 to UTF-16 stream decoder.
// Used by the port checker; no other dependencies.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8u16 assertion failed");

// next-cycle implication
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8u16 assertion failed");

`endif

// File: hdl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 stream decoder.
// Types, byte constants and held-state codes; no dependencies.
package u8u16_pkg;

	localparam int BYTE_W   = 8;
	localparam int UNIT_W   = 16;
	localparam int MAX_RES  = 3;
	localparam int RES_CNT_W = 2;

	localparam logic [BYTE_W-1:0] BYTE_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] LEAD_MIN    = 8'hc2;
	localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hdf;
	localparam logic [BYTE_W-1:0] LEAD_MAX    = 8'hef;
	localparam logic [BYTE_W-1:0] CONT_MIN    = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_MAX    = 8'hbf;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	typedef struct packed {
		logic [1:0]        count;
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] cont;
	} hold_t;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              run_last;
		logic              string_end;
	} result_t;

	typedef struct packed {
		result_t [MAX_RES-1:0]  res;
		logic [RES_CNT_W-1:0]   n;
		hold_t                  nxt;
	} dec_t;

endpackage

// File: hdl/u8u16_if.sv
// Handshake channels for the UTF-8 to UTF-16 stream decoder.
// Depends on u8u16_pkg.
interface u8u16_byte_if;
	import u8u16_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	modport source (output valid, in_byte, input ready);
	modport sink (input valid, in_byte, output ready);
endinterface

interface u8u16_unit_if;
	import u8u16_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              run_last;
	logic              string_end;
	modport source (output valid, code_unit, run_last, string_end, input ready);
	modport sink (input valid, code_unit, run_last, string_end, output ready);
endinterface

// File: hdl/u8u16_decode.sv
// Combinational decode of one byte against the held sequence state.
// Produces up to three results and the next held state. Depends on u8u16_pkg.
module u8u16_decode (
	input  u8u16_pkg::hold_t            held,
	input  logic [u8u16_pkg::BYTE_W-1:0] in_byte,
	output u8u16_pkg::dec_t             dec
);
	import u8u16_pkg::*;

	logic                 is_cont;
	logic                 fresh;
	logic [RES_CNT_W-1:0] n;
	logic [UNIT_W-1:0]    units [MAX_RES];
	logic [MAX_RES-1:0]   ends;
	hold_t                nxt;

	assign is_cont = in_byte inside {[CONT_MIN:CONT_MAX]};

	always_comb begin
		n     = '0;
		fresh = 1'b1;
		ends  = '0;
		nxt   = held;
		nxt.count = HELD_NONE;
		for (int i = 0; i < MAX_RES; i++) begin
			units[i] = '0;
		end
		case (held.count)
			HELD_ONE: begin
				if (is_cont) begin
					fresh = 1'b0;
					if (held.lead <= LEAD2_MAX) begin
						units[0] = {4'h0, held.lead[5:0], in_byte[5:0]};
						n        = 2'd1;
					end else begin
						nxt.cont  = in_byte;
						nxt.count = HELD_TWO;
					end
				end else begin
					units[0] = {8'h00, held.lead};
					n        = 2'd1;
				end
			end
			HELD_TWO: begin
				if (is_cont) begin
					fresh    = 1'b0;
					units[0] = {held.lead[3:0], held.cont[5:0], in_byte[5:0]};
					n        = 2'd1;
				end else begin
					units[0] = {8'h00, held.lead};
					units[1] = {8'h00, held.cont};
					n        = 2'd2;
				end
			end
			default: begin
			end
		endcase
		if (fresh) begin
			if (in_byte == BYTE_NUL) begin
				units[n] = '0;
				ends[n]  = 1'b1;
				n        = n + 2'd1;
			end else if (in_byte inside {[LEAD_MIN:LEAD_MAX]}) begin
				nxt.lead  = in_byte;
				nxt.count = HELD_ONE;
			end else begin
				units[n] = {8'h00, in_byte};
				n        = n + 2'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			dec.res[i].code_unit  = units[i];
			dec.res[i].string_end = ends[i];
			dec.res[i].run_last   = (n != '0) && (RES_CNT_W'(i) == n - 2'd1);
		end
		dec.n   = n;
		dec.nxt = nxt;
	end

endmodule

// File: hdl/u8u16_queue.sv
// Result register holding up to three pending results, shifted out one per cycle while out_ready is high.
// Depends on u8u16_pkg.
module u8u16_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  u8u16_pkg::dec_t     dec,
	input  logic                out_ready,
	output logic                out_valid,
	output u8u16_pkg::result_t  head,
	output logic                can_load
);
	import u8u16_pkg::*;

	result_t              slots_q [MAX_RES];
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign can_load  = (cnt_q == '0) || ((cnt_q == 2'd1) && out_ready);
	assign head      = slots_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= dec.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				slots_q[i] <= dec.res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				slots_q[i] <= slots_q[i+1];
			end
		end
	end

endmodule

// File: hdl/utf8_to_utf16_stream_decoder.sv
// UTF-8 to UTF-16 stream decoder, top level. Takes one byte per transaction and
// gives 16-bit code units. Depends on u8u16_pkg, u8u16_if, u8u16_decode, u8u16_queue.
// A byte is decoded in the cycle it is accepted and its results (zero to three) sit in
// a three-entry result register from the next cycle on, one leaving per cycle while
// the receiver is ready. A byte is accepted every cycle while each gives at most one
// result and the receiver is ready; a byte with more holds the input while the result
// register drains. The first result is offered in the next cycle. No clearing pass.
module utf8_to_utf16_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	u8u16_byte_if.sink          bytes_ch,
	u8u16_unit_if.source        units_ch
);
	import u8u16_pkg::*;

	hold_t   held_q;
	dec_t    dec;
	result_t head;
	logic    can_load;
	logic    accept;

	assign bytes_ch.ready = can_load;
	assign accept         = bytes_ch.valid && can_load;

	u8u16_decode u_decode (
		.held    (held_q),
		.in_byte (bytes_ch.in_byte),
		.dec     (dec)
	);

	u8u16_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.dec       (dec),
		.out_ready (units_ch.ready),
		.out_valid (units_ch.valid),
		.head      (head),
		.can_load  (can_load)
	);

	assign units_ch.code_unit  = head.code_unit;
	assign units_ch.run_last   = head.run_last;
	assign units_ch.string_end = head.string_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept) begin
			held_q <= dec.nxt;
		end
	end

endmodule

// File: hdl/u8u16_checker.sv
// Port-level checker for the UTF-8 to UTF-16 stream decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_stream_decoder_assert.svh.
`include "utf8_to_utf16_stream_decoder_assert.svh"

module u8u16_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [u8u16_pkg::BYTE_W-1:0] in_byte,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [u8u16_pkg::UNIT_W-1:0] code_unit,
	input logic                         run_last,
	input logic                         string_end
);
	import u8u16_pkg::*;

	`U8U16_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({code_unit, run_last, string_end}))
	`U8U16_ASSERT_IMPLY(a_term_shape, clk, arst_n, out_valid && string_end, code_unit == '0 && run_last)
	`U8U16_ASSERT_NEXT(a_nul_result, clk, arst_n, in_valid && in_ready && in_byte == BYTE_NUL, out_valid)
	`U8U16_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, out_valid)

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (bytes_ch.valid),
	.in_ready   (bytes_ch.ready),
	.in_byte    (bytes_ch.in_byte),
	.out_valid  (units_ch.valid),
	.out_ready  (units_ch.ready),
	.code_unit  (units_ch.code_unit),
	.run_last   (units_ch.run_last),
	.string_end (units_ch.string_end)
);

// File: bench/utf8_to_utf16_stream_decoder_tb.sv
// Testbench for utf8_to_utf16_stream_decoder: directed byte table, then random UTF-8 traffic
// under four idle/stall phases; units checked against typed rows or an in-bench decoder.
// Depends on u8u16_pkg, u8u16_if and the decoder RTL.
module utf8_to_utf16_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import u8u16_pkg::*;

	typedef result_t [0:2] unit_trio_t;

	typedef struct {
		logic [BYTE_W-1:0] in_byte;
		int                n_typed;
		unit_trio_t        units;
	} byte_row_t;

	localparam int      PREDICT = -1;
	localparam result_t NO_UNIT = '0;
	localparam int      PHASE_CNT = 4;
	localparam int      BYTES_PER_PHASE = 56;

	// typed rows: after reset, extremes, raw pass-through, a held lead, a flush on zero
	byte_row_t byte_table [0:24] = '{
		'{8'h00, 1, '{'{16'h0000, 1'b1, 1'b1}, NO_UNIT, NO_UNIT}},
		'{8'h41, 1, '{'{16'h0041, 1'b1, 1'b0}, NO_UNIT, NO_UNIT}},
		'{8'hff, 1, '{'{16'h00ff, 1'b1, 1'b0}, NO_UNIT, NO_UNIT}},
		'{8'hc0, 1, '{'{16'h00c0, 1'b1, 1'b0}, NO_UNIT, NO_UNIT}},
		'{8'hc2, 0, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h80, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hdf, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hbf, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'he0, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h80, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h80, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hef, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hbf, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hbf, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hc5, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h41, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'he5, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h90, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h20, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'he5, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'hc3, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'ha9, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'he1, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h81, PREDICT, '{NO_UNIT, NO_UNIT, NO_UNIT}},
		'{8'h00, 3, '{'{16'h00e1, 1'b0, 1'b0}, '{16'h0081, 1'b0, 1'b0},
			'{16'h0000, 1'b1, 1'b1}}}
	};

	int sender_idle_pct [0:PHASE_CNT-1] = '{0, 61, 0, 16};
	int recv_stall_pct [0:PHASE_CNT-1]  = '{0, 0, 61, 16};

	logic clk;
	logic arst_n = 1'b0;

	u8u16_byte_if bytes_ch ();
	u8u16_unit_if units_ch ();

	utf8_to_utf16_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_ch (bytes_ch),
		.units_ch (units_ch)
	);

	// decoder state of the bench
	logic [1:0]        hold_cnt  = HELD_NONE;
	logic [BYTE_W-1:0] hold_lead = '0;
	logic [BYTE_W-1:0] hold_cont = '0;

	result_t pending_units [$];
	int idle_pct = 0;
	int stall_pct = 0;
	int fault_count = 0;
	int bytes_sent = 0;
	int units_checked = 0;
	int strings_ended = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("status: fail");
		$finish;
	end

	function automatic int decode_byte(input logic [BYTE_W-1:0] b, output unit_trio_t u);
		int   n;
		logic fresh;
		logic is_cont;
		n = 0;
		fresh = 1'b0;
		u = '0;
		is_cont = (b >= CONT_MIN) && (b <= CONT_MAX);
		case (hold_cnt)
			HELD_ONE: begin
				if (is_cont && hold_lead <= LEAD2_MAX) begin
					u[n] = '{{4'b0, hold_lead[5:0], b[5:0]}, 1'b0, 1'b0};
					n = n + 1;
					hold_cnt = HELD_NONE;
				end else if (is_cont) begin
					hold_cont = b;
					hold_cnt = HELD_TWO;
				end else begin
					u[n] = '{{8'h00, hold_lead}, 1'b0, 1'b0};
					n = n + 1;
					hold_cnt = HELD_NONE;
					fresh = 1'b1;
				end
			end
			HELD_TWO: begin
				hold_cnt = HELD_NONE;
				if (is_cont) begin
					u[n] = '{{hold_lead[3:0], hold_cont[5:0], b[5:0]}, 1'b0, 1'b0};
					n = n + 1;
				end else begin
					u[n] = '{{8'h00, hold_lead}, 1'b0, 1'b0};
					u[n+1] = '{{8'h00, hold_cont}, 1'b0, 1'b0};
					n = n + 2;
					fresh = 1'b1;
				end
			end
			default: begin
				hold_cnt = HELD_NONE;
				fresh = 1'b1;
			end
		endcase
		if (fresh) begin
			if (b == BYTE_NUL) begin
				u[n] = '{16'h0000, 1'b0, 1'b1};
				n = n + 1;
			end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
				hold_lead = b;
				hold_cnt = HELD_ONE;
			end else begin
				u[n] = '{{8'h00, b}, 1'b0, 1'b0};
				n = n + 1;
			end
		end
		if (n > 0)
			u[n-1].run_last = 1'b1;
		return n;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input int n_typed,
			input unit_trio_t typed);
		unit_trio_t predicted;
		int         n;
		while ($urandom_range(99) < idle_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.in_byte <= b;
		do @(posedge clk); while (!bytes_ch.ready);
		n = decode_byte(b, predicted);
		if (n_typed != PREDICT) begin
			n = n_typed;
			predicted = typed;
		end
		for (int i = 0; i < n; i++)
			pending_units.push_back(predicted[i]);
		bytes_sent++;
	endtask

	task automatic send_utf8_sequence();
		int                kind;
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] brk;
		kind = $urandom_range(99);
		if (kind < 25) begin
			send_byte(8'($urandom_range(1, 8'h7f)), PREDICT, '0);
		end else if (kind < 50) begin
			send_byte(8'($urandom_range(LEAD_MIN, LEAD2_MAX)), PREDICT, '0);
			send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)), PREDICT, '0);
		end else if (kind < 72) begin
			send_byte(8'($urandom_range(8'he0, LEAD_MAX)), PREDICT, '0);
			send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)), PREDICT, '0);
			send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)), PREDICT, '0);
		end else if (kind < 80) begin
			send_byte(BYTE_NUL, PREDICT, '0);
		end else if (kind < 90) begin
			// broken sequence: lead, maybe one continuation, then a non-continuation
			lead = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
			send_byte(lead, PREDICT, '0);
			if (lead > LEAD2_MAX && $urandom_range(1) == 1)
				send_byte(8'($urandom_range(CONT_MIN, CONT_MAX)), PREDICT, '0);
			do brk = 8'($urandom_range(255)); while (brk >= CONT_MIN && brk <= CONT_MAX);
			send_byte(brk, PREDICT, '0);
		end else begin
			send_byte(8'($urandom_range(255)), PREDICT, '0);
		end
	endtask

	// receiver: random stalls per phase
	initial begin
		units_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			units_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && units_ch.valid && units_ch.ready) begin
			if (pending_units.size() == 0) begin
				$error("code unit %h arrived with none expected", units_ch.code_unit);
				fault_count++;
			end else begin
				if (units_ch.code_unit !== pending_units[0].code_unit) begin
					$error("code_unit expected %h actual %h",
						pending_units[0].code_unit, units_ch.code_unit);
					fault_count++;
				end
				if (units_ch.run_last !== pending_units[0].run_last) begin
					$error("run_last expected %b actual %b",
						pending_units[0].run_last, units_ch.run_last);
					fault_count++;
				end
				if (units_ch.string_end !== pending_units[0].string_end) begin
					$error("string_end expected %b actual %b",
						pending_units[0].string_end, units_ch.string_end);
					fault_count++;
				end
				void'(pending_units.pop_front());
			end
			units_checked++;
			if (units_ch.string_end === 1'b1)
				strings_ended++;
		end
	end

	initial begin
		int phase_start;
		int drain_wait;
		bytes_ch.valid <= 1'b0;
		bytes_ch.in_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (byte_table[i])
			send_byte(byte_table[i].in_byte, byte_table[i].n_typed, byte_table[i].units);

		for (int p = 0; p < PHASE_CNT; p++) begin
			// sender holds off until every pending unit has come out
			bytes_ch.valid <= 1'b0;
			do @(posedge clk); while (pending_units.size() != 0);
			idle_pct = sender_idle_pct[p];
			stall_pct = recv_stall_pct[p];
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < BYTES_PER_PHASE)
				send_utf8_sequence();
		end

		bytes_ch.valid <= 1'b0;
		drain_wait = 0;
		while (pending_units.size() != 0 && drain_wait < 5000) begin
			@(posedge clk);
			drain_wait++;
		end
		if (pending_units.size() != 0) begin
			$error("%0d code units never arrived", pending_units.size());
			fault_count++;
		end
		repeat (8) @(posedge clk);

		$display("covered %0d bytes (directed table plus random UTF-8 under 4 flow phases)",
			bytes_sent);
		$display("checked %0d code units, %0d string terminators", units_checked,
			strings_ended);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: utf8_to_utf16_stream_decoder.f
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/u8u16_if.sv
hdl/u8u16_decode.sv
hdl/u8u16_queue.sv
hdl/utf8_to_utf16_stream_decoder.sv
hdl/u8u16_checker.sv
bench/utf8_to_utf16_stream_decoder_tb.sv
